// ===== rtl/core/banked_bounded_list_store_top_macros.svh =====
// Assertion macros for the list store checker.
`ifndef BANKED_BOUNDED_LIST_STORE_TOP_MACROS_SVH
`define BANKED_BOUNDED_LIST_STORE_TOP_MACROS_SVH

// Clocked assertion, held off during reset.
`define BBLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define BBLS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/bbls_pkg.sv =====
package bbls_pkg;

    localparam int CW = 7;

    localparam logic [2:0] K_CREATE   = 3'd0;
    localparam logic [2:0] K_APPEND   = 3'd1;
    localparam logic [2:0] K_RM_LAST  = 3'd2;
    localparam logic [2:0] K_RM_VALUE = 3'd3;
    localparam logic [2:0] K_READ     = 3'd4;
    localparam logic [2:0] K_SORTED   = 3'd5;
    localparam logic [2:0] K_COUNT    = 3'd6;
    localparam logic [2:0] K_RESIZE   = 3'd7;

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_SLOT     = 4'd1;
    localparam logic [3:0] ST_BAD_SIZE     = 4'd2;
    localparam logic [3:0] ST_EXISTS       = 4'd3;
    localparam logic [3:0] ST_NO_MEMORY    = 4'd4;
    localparam logic [3:0] ST_FULL         = 4'd5;
    localparam logic [3:0] ST_NONE         = 4'd6;
    localparam logic [3:0] ST_EMPTY        = 4'd7;
    localparam logic [3:0] ST_NOT_FOUND    = 4'd8;
    localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd9;

    typedef logic [CW-1:0] t_cnt;

endpackage

// ===== rtl/core/banked_bounded_list_store_top.sv =====
// Banked list store: NUM_SLOTS slots, 1-based, each an ordered list of up to MAX_CAPACITY
// signed words kept in one synchronous word memory (one write and one read per cycle,
// read data registered). One operation runs at a time; o_ready is high only while idle.
// Remove by value scans the list for the value, then shifts each later word down one place.
// A read fetches each word from the memory before that word's beat. A sorted read rescans
// the list for each word it returns. Each word of a read is one beat, the last marked; a
// stalled beat holds the block until it is taken.
module banked_bounded_list_store_top #(
    parameter int NUM_SLOTS    = 16,
    parameter int MAX_CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [4:0]  i_slot,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_new_size,
    input  logic [7:0]  i_size_change,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [31:0] o_element,
    output logic [5:0]  o_count,
    output logic        o_last
);

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int DEPTH = NUM_SLOTS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = bbls_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_FIND_RD, S_FIND_CK, S_SHIFT_RD, S_SHIFT_WR,
        S_RD_RD, S_RD_CK, S_SORT_RD, S_SORT_CK, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    bbls_pkg::t_cnt r_fill [NUM_SLOTS];
    bbls_pkg::t_cnt r_cap  [NUM_SLOTS];
    logic           r_exist [NUM_SLOTS];

    logic [2:0]     r_kind;
    logic           r_slot_ok;
    logic [SW-1:0]  r_s;
    logic [31:0]    r_value;
    logic [7:0]     r_nsize;
    logic [7:0]     r_delta;
    bbls_pkg::t_cnt r_n;
    bbls_pkg::t_cnt r_ptr;
    bbls_pkg::t_cnt r_k;
    logic           r_bv;
    logic [31:0]    r_bestv;
    bbls_pkg::t_cnt r_besti;
    logic [31:0]    r_prevv;
    bbls_pkg::t_cnt r_previ;

    logic           r_ovalid;
    logic [3:0]     r_status;
    logic [31:0]    r_elem;
    bbls_pkg::t_cnt r_cnt;
    logic           r_last;

    logic [3:0]     n_status;
    bbls_pkg::t_cnt n_cnt;

    logic [5:0]     slot_m1;
    bbls_pkg::t_cnt cur_fill;
    bbls_pkg::t_cnt cur_cap;
    logic           cur_ex;
    bbls_pkg::t_cnt ex_fill;
    logic [8:0]     n_cap;
    bbls_pkg::t_cnt clip_fill;
    bbls_pkg::t_cnt ptr_inc;
    logic           gt_prev;
    logic           better;
    logic           take;
    logic [31:0]    sel_v;
    bbls_pkg::t_cnt sel_i;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [31:0]    mem_wdata;
    logic [AW-1:0]  mem_raddr;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] s, input bbls_pkg::t_cnt p);
        return AW'(s) * AW'(MAX_CAPACITY) + AW'(p[PW-1:0]);
    endfunction

    assign slot_m1   = {1'b0, i_slot} - 6'd1;
    assign cur_fill  = r_fill[r_s];
    assign cur_cap   = r_cap[r_s];
    assign cur_ex    = r_exist[r_s];
    assign ex_fill   = cur_ex ? cur_fill : '0;
    assign n_cap     = $signed({2'b00, (cur_ex ? cur_cap : CW'(0))})
                     + $signed({r_delta[7], r_delta});
    assign clip_fill = (cur_fill > n_cap[CW-1:0]) ? n_cap[CW-1:0] : cur_fill;
    assign ptr_inc   = r_ptr + CW'(1);

    assign gt_prev = (r_k == '0) || ($signed(r_rdata) > $signed(r_prevv))
                   || ((r_rdata == r_prevv) && (r_ptr > r_previ));
    assign better  = !r_bv || ($signed(r_rdata) < $signed(r_bestv));
    assign take    = gt_prev && better;
    assign sel_v   = take ? r_rdata : r_bestv;
    assign sel_i   = take ? r_ptr : r_besti;

    always_comb begin
        n_status = bbls_pkg::ST_OK;
        n_cnt    = '0;
        n_state  = S_OUT;
        if (!r_slot_ok) begin
            n_status = bbls_pkg::ST_BAD_SLOT;
        end else if (r_kind == bbls_pkg::K_CREATE) begin
            n_cnt = ex_fill;
            if ($signed(r_nsize) < 8'sd1) begin
                n_status = bbls_pkg::ST_BAD_SIZE;
            end else if (cur_ex) begin
                n_status = bbls_pkg::ST_EXISTS;
            end else if ($signed(r_nsize) > $signed(8'(MAX_CAPACITY))) begin
                n_status = bbls_pkg::ST_NO_MEMORY;
            end
        end else if (r_kind == bbls_pkg::K_RESIZE) begin
            n_cnt = ex_fill;
            if ($signed(n_cap) < 9'sd1) begin
                n_status = bbls_pkg::ST_BAD_NEW_SIZE;
            end else if (!cur_ex) begin
                n_status = bbls_pkg::ST_NONE;
            end else if ($signed(n_cap) > $signed(9'(MAX_CAPACITY))) begin
                n_status = bbls_pkg::ST_NO_MEMORY;
            end else begin
                n_cnt = clip_fill;
            end
        end else if (!cur_ex) begin
            n_status = bbls_pkg::ST_NONE;
        end else begin
            case (r_kind)
                bbls_pkg::K_APPEND: begin
                    if (cur_fill >= cur_cap) begin
                        n_status = bbls_pkg::ST_FULL;
                        n_cnt    = cur_fill;
                    end else begin
                        n_cnt = cur_fill + CW'(1);
                    end
                end
                bbls_pkg::K_RM_LAST, bbls_pkg::K_RM_VALUE: begin
                    if (cur_fill == '0) begin
                        n_status = bbls_pkg::ST_EMPTY;
                    end else if (r_kind == bbls_pkg::K_RM_LAST) begin
                        n_cnt = cur_fill - CW'(1);
                    end else begin
                        n_state = S_FIND_RD;
                    end
                end
                bbls_pkg::K_READ, bbls_pkg::K_SORTED: begin
                    if (cur_fill != '0) begin
                        n_state = (r_kind == bbls_pkg::K_READ) ? S_RD_RD : S_SORT_RD;
                    end
                end
                default: begin
                    n_cnt = cur_fill;
                end
            endcase
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = f_addr(r_s, r_ptr);
        mem_wdata = r_rdata;
        mem_raddr = (r_state == S_SHIFT_RD) ? f_addr(r_s, ptr_inc) : f_addr(r_s, r_ptr);
        if (r_state == S_DEC && r_slot_ok && r_kind == bbls_pkg::K_APPEND && cur_ex
            && cur_fill < cur_cap) begin
            mem_we    = 1'b1;
            mem_waddr = f_addr(r_s, cur_fill);
            mem_wdata = r_value;
        end else if (r_state == S_SHIFT_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_fill[i]  <= '0;
                r_cap[i]   <= '0;
                r_exist[i] <= 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind    <= i_kind;
                        r_slot_ok <= (i_slot != 5'd0) && (32'(i_slot) <= 32'(NUM_SLOTS));
                        r_s       <= slot_m1[SW-1:0];
                        r_value   <= i_value;
                        r_nsize   <= i_new_size;
                        r_delta   <= i_size_change;
                        r_state   <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_elem   <= '0;
                    r_last   <= 1'b1;
                    r_ovalid <= (n_state == S_OUT);
                    r_state  <= n_state;
                    r_status <= n_status;
                    r_cnt    <= n_cnt;
                    r_n      <= cur_fill;
                    r_ptr    <= '0;
                    r_k      <= '0;
                    r_bv     <= 1'b0;
                    if (n_status == bbls_pkg::ST_OK) begin
                        if (r_kind == bbls_pkg::K_CREATE) begin
                            r_exist[r_s] <= 1'b1;
                            r_cap[r_s]   <= r_nsize[CW-1:0];
                            r_fill[r_s]  <= '0;
                        end else if (r_kind == bbls_pkg::K_RESIZE) begin
                            r_cap[r_s]  <= n_cap[CW-1:0];
                            r_fill[r_s] <= clip_fill;
                        end else if (r_kind == bbls_pkg::K_APPEND
                                     || r_kind == bbls_pkg::K_RM_LAST) begin
                            r_fill[r_s] <= n_cnt;
                        end
                    end
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CK;
                end
                S_FIND_CK: begin
                    if (r_rdata == r_value) begin
                        r_state <= S_SHIFT_RD;
                    end else if (ptr_inc == r_n) begin
                        r_status <= bbls_pkg::ST_NOT_FOUND;
                        r_cnt    <= r_n;
                        r_elem   <= '0;
                        r_last   <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_ptr   <= ptr_inc;
                        r_state <= S_FIND_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (ptr_inc < r_n) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_fill[r_s] <= r_n - CW'(1);
                        r_status    <= bbls_pkg::ST_OK;
                        r_cnt       <= r_n - CW'(1);
                        r_elem      <= '0;
                        r_last      <= 1'b1;
                        r_ovalid    <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_SHIFT_WR: begin
                    r_ptr   <= ptr_inc;
                    r_state <= S_SHIFT_RD;
                end
                S_RD_RD: begin
                    r_state <= S_RD_CK;
                end
                S_RD_CK: begin
                    r_status <= bbls_pkg::ST_OK;
                    r_elem   <= r_rdata;
                    r_cnt    <= r_n;
                    r_last   <= (ptr_inc == r_n);
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_SORT_RD: begin
                    r_state <= S_SORT_CK;
                end
                S_SORT_CK: begin
                    r_bv    <= r_bv | take;
                    r_bestv <= sel_v;
                    r_besti <= sel_i;
                    if (ptr_inc == r_n) begin
                        r_prevv  <= sel_v;
                        r_previ  <= sel_i;
                        r_status <= bbls_pkg::ST_OK;
                        r_elem   <= sel_v;
                        r_cnt    <= r_n;
                        r_last   <= (r_k + CW'(1) == r_n);
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_ptr   <= ptr_inc;
                        r_state <= S_SORT_RD;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else if (r_kind == bbls_pkg::K_SORTED) begin
                            r_k     <= r_k + CW'(1);
                            r_ptr   <= '0;
                            r_bv    <= 1'b0;
                            r_state <= S_SORT_RD;
                        end else begin
                            r_ptr   <= ptr_inc;
                            r_state <= S_RD_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_status  = r_status;
    assign o_element = r_elem;
    assign o_count   = r_cnt[5:0];
    assign o_last    = r_last;

endmodule

// ===== rtl/core/bbls_checker.sv =====
`include "banked_bounded_list_store_top_macros.svh"

module bbls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_kind,
    input logic [4:0]  i_slot,
    input logic [31:0] i_value,
    input logic [7:0]  i_new_size,
    input logic [7:0]  i_size_change,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_status,
    input logic [31:0] o_element,
    input logic [5:0]  o_count,
    input logic        o_last
);

    `BBLS_ASSERT(a_out_hold,
        o_valid && !i_ready |=> o_valid && $stable(o_element) && $stable(o_status),
        "result beat changed while stalled")
    `BBLS_NEVER(a_no_overlap, o_ready && o_valid,
        "input taken while a result is pending")
    `BBLS_ASSERT(a_err_single,
        o_valid && o_status != bbls_pkg::ST_OK |-> o_last && o_element == 32'd0,
        "error result not a single beat")
    `BBLS_ASSERT(a_bad_slot_cnt,
        o_valid && (o_status == bbls_pkg::ST_BAD_SLOT || o_status == bbls_pkg::ST_NONE)
            |-> o_count == 6'd0,
        "count nonzero for missing slot")

endmodule

bind banked_bounded_list_store_top bbls_checker u_bbls_checker (.*);
